### hdl/cluster_chain_allocator_defines.svh
// Assertion macros used by the checker file of the cluster chain allocator.
`ifndef CLUSTER_CHAIN_ALLOCATOR_DEFINES_SVH
`define CLUSTER_CHAIN_ALLOCATOR_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define CCA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cca_pkg.sv
// Types and constants of the cluster chain allocator.
`default_nettype none
package cca_pkg;
   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int STATE_W = 2;
   localparam int ENTRY_W = STATE_W + IDX_W;
   localparam int CMD_W = 3;
   localparam int STATUS_W = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] TABLE_SIZE = CNT_W'(TABLE_ENTRIES);

   // entry states
   localparam logic [STATE_W-1:0] ENT_FREE = 2'd0;
   localparam logic [STATE_W-1:0] ENT_ALLOC = 2'd1;
   localparam logic [STATE_W-1:0] ENT_LAST = 2'd2;

   // commands
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EXTEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FREE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SHRINK = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd2;
   localparam logic [STATUS_W-1:0] STS_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NOT_LAST = 3'd4;
   localparam logic [STATUS_W-1:0] STS_BROKEN = 3'd5;

   // register indexes
   localparam int REG_CLUSTERS_IN_USE = 0;

   typedef struct packed {
      logic [CNT_W-1:0] active_count;
   } cca_cfg_type;
endpackage
`default_nettype wire

### hdl/cluster_chain_allocator.sv
// Cluster chain allocator: allocation table of clusters with chain commands.
// After reset the table is cleared to free, one entry a cycle; requests
// stall meanwhile. Each command then works through the table's single
// read port: a lookup reads the entry and then checks it, an allocate or
// extend scans for the lowest free entry, reading and checking one entry
// after another (up to n entries, n being clusters_in_use capped at 1024),
// and a free or shrink walks the chain, reading and checking each link. One
// command is in work at a time; its result sits in an output register, so
// the next request is taken while it waits.
`default_nettype none
module cluster_chain_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [cca_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [cca_pkg::IDX_W-1:0]        req_cluster_index,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [cca_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [cca_pkg::IDX_W-1:0]        rsp_result_index,
   output logic      [cca_pkg::STATE_W-1:0]      rsp_entry_state,
   output logic      [cca_pkg::IDX_W-1:0]        rsp_entry_next,
   output logic      [cca_pkg::CNT_W-1:0]        rsp_allocated_count,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [cca_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [cca_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [cca_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import cca_pkg::*;

   cca_cfg_type        cfg;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;

   cca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cca_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cca_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_cluster_index   (req_cluster_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_result_index    (rsp_result_index),
      .rsp_entry_state     (rsp_entry_state),
      .rsp_entry_next      (rsp_entry_next),
      .rsp_allocated_count (rsp_allocated_count),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data)
   );
endmodule
`default_nettype wire

### hdl/cca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### hdl/cca_csr.sv
// Configuration register file of the cluster chain allocator.
`default_nettype none
module cca_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cca_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cca_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cca_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output cca_pkg::cca_cfg_type                cfg
);
   import cca_pkg::*;

   logic [CNT_W-1:0] clusters_ff;
   logic [CNT_W-1:0] clusters_in;
   logic             wr_hit;

   assign wr_hit = psel && penable && pwrite
                   && (paddr == CSR_ADDR_W'(4 * REG_CLUSTERS_IN_USE));

   always_comb begin
      clusters_in = clusters_ff;
      if (wr_hit) begin
         clusters_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= TABLE_SIZE;
      end else begin
         clusters_ff <= clusters_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = CSR_DATA_W'(clusters_ff);
   // clamp to the table size
   assign cfg.active_count = (clusters_ff > TABLE_SIZE) ? TABLE_SIZE : clusters_ff;
endmodule
`default_nettype wire

### hdl/cca_seq.sv
// Command sequencer: scans, chain walks and table updates through one read and one write port of the table.
`default_nettype none
module cca_seq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cca_pkg::cca_cfg_type         cfg,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [cca_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [cca_pkg::IDX_W-1:0]    req_cluster_index,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [cca_pkg::STATUS_W-1:0] rsp_status,
   output logic      [cca_pkg::IDX_W-1:0]    rsp_result_index,
   output logic      [cca_pkg::STATE_W-1:0]  rsp_entry_state,
   output logic      [cca_pkg::IDX_W-1:0]    rsp_entry_next,
   output logic      [cca_pkg::CNT_W-1:0]    rsp_allocated_count,
   output logic                              mem_wr_en,
   output logic      [cca_pkg::IDX_W-1:0]    mem_wr_addr,
   output logic      [cca_pkg::ENTRY_W-1:0]  mem_wr_data,
   output logic      [cca_pkg::IDX_W-1:0]    mem_rd_addr,
   input  wire logic [cca_pkg::ENTRY_W-1:0]  mem_rd_data
);
   import cca_pkg::*;

   localparam logic [3:0] SQ_CLEAR = 4'd0;
   localparam logic [3:0] SQ_IDLE = 4'd1;
   localparam logic [3:0] SQ_START = 4'd2;
   localparam logic [3:0] SQ_RD_IDX = 4'd3;
   localparam logic [3:0] SQ_CK_IDX = 4'd4;
   localparam logic [3:0] SQ_SCAN_RD = 4'd5;
   localparam logic [3:0] SQ_SCAN_CK = 4'd6;
   localparam logic [3:0] SQ_EXT_LINK = 4'd7;
   localparam logic [3:0] SQ_WALK_RD = 4'd8;
   localparam logic [3:0] SQ_WALK_CK = 4'd9;
   localparam logic [3:0] SQ_FIX = 4'd10;
   localparam logic [3:0] SQ_DONE = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic                flag_ff, flag_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [STATUS_W-1:0] sts_ff, sts_in;
   logic [IDX_W-1:0]    res_ff, res_in;
   logic [STATE_W-1:0]  est_ff, est_in;
   logic [IDX_W-1:0]    enx_ff, enx_in;
   logic                ov_ff, ov_in;
   logic [STATUS_W-1:0] o_sts_ff, o_sts_in;
   logic [IDX_W-1:0]    o_res_ff, o_res_in;
   logic [STATE_W-1:0]  o_est_ff, o_est_in;
   logic [IDX_W-1:0]    o_enx_ff, o_enx_in;
   logic [CNT_W-1:0]    o_cnt_ff, o_cnt_in;

   logic [STATE_W-1:0]  rd_state;
   logic [IDX_W-1:0]    rd_link;
   logic [CNT_W-1:0]    ptr_inc;
   logic [CNT_W-1:0]    steps_inc;

   assign rd_state = mem_rd_data[ENTRY_W-1:IDX_W];
   assign rd_link = mem_rd_data[IDX_W-1:0];
   assign ptr_inc = ptr_ff + 1'b1;
   assign steps_inc = steps_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      ptr_in = ptr_ff;
      steps_in = steps_ff;
      flag_in = flag_ff;
      used_in = used_ff;
      sts_in = sts_ff;
      res_in = res_ff;
      est_in = est_ff;
      enx_in = enx_ff;
      ov_in = ov_ff && rsp_stall;
      o_sts_in = o_sts_ff;
      o_res_in = o_res_ff;
      o_est_in = o_est_ff;
      o_enx_in = o_enx_ff;
      o_cnt_in = o_cnt_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = ptr_ff[IDX_W-1:0];
      mem_wr_data = {ENT_FREE, {IDX_W{1'b0}}};
      mem_rd_addr = ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         SQ_CLEAR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = SQ_IDLE;
            end
         end
         SQ_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               idx_in = req_cluster_index;
               n_in = cfg.active_count;
               sts_in = STS_OK;
               res_in = '0;
               est_in = ENT_FREE;
               enx_in = '0;
               state_in = SQ_START;
            end
         end
         SQ_START: begin
            ptr_in = '0;
            if (cmd_ff == CMD_ALLOC) begin
               if (n_ff == '0) begin
                  sts_in = STS_FULL;
                  state_in = SQ_DONE;
               end else begin
                  state_in = SQ_SCAN_RD;
               end
            end else if (cmd_ff == CMD_EXTEND || cmd_ff == CMD_FREE
                         || cmd_ff == CMD_SHRINK || cmd_ff == CMD_READ) begin
               if ({1'b0, idx_ff} >= n_ff) begin
                  sts_in = STS_BAD_INDEX;
                  state_in = SQ_DONE;
               end else begin
                  state_in = SQ_RD_IDX;
               end
            end else begin
               state_in = SQ_DONE;
            end
         end
         SQ_RD_IDX: begin
            mem_rd_addr = idx_ff;
            state_in = SQ_CK_IDX;
         end
         SQ_CK_IDX: begin
            est_in = rd_state;
            enx_in = (rd_state == ENT_ALLOC) ? rd_link : '0;
            ptr_in = {1'b0, idx_ff};
            steps_in = '0;
            flag_in = 1'b0;
            state_in = SQ_DONE;
            if (cmd_ff != CMD_READ) begin
               if (rd_state == ENT_FREE) begin
                  sts_in = STS_NOT_ALLOC;
               end else if (cmd_ff == CMD_EXTEND) begin
                  if (rd_state != ENT_LAST) begin
                     sts_in = STS_NOT_LAST;
                  end else begin
                     ptr_in = '0;
                     state_in = SQ_SCAN_RD;
                  end
               end else if (cmd_ff == CMD_FREE) begin
                  est_in = ENT_FREE;
                  enx_in = '0;
                  state_in = SQ_WALK_RD;
               end else if (rd_state == ENT_ALLOC) begin
                  // shrink: cut here, then free the tail
                  mem_wr_en = 1'b1;
                  mem_wr_addr = idx_ff;
                  mem_wr_data = {ENT_LAST, {IDX_W{1'b0}}};
                  est_in = ENT_LAST;
                  enx_in = '0;
                  ptr_in = {1'b0, rd_link};
                  if ({1'b0, rd_link} >= n_ff) begin
                     sts_in = STS_BROKEN;
                  end else begin
                     state_in = SQ_WALK_RD;
                  end
               end
            end
         end
         SQ_SCAN_RD: begin
            state_in = SQ_SCAN_CK;
         end
         SQ_SCAN_CK: begin
            if (rd_state == ENT_FREE) begin
               mem_wr_en = 1'b1;
               mem_wr_data = {ENT_LAST, {IDX_W{1'b0}}};
               used_in = used_ff + 1'b1;
               res_in = ptr_ff[IDX_W-1:0];
               if (cmd_ff == CMD_ALLOC) begin
                  est_in = ENT_LAST;
                  state_in = SQ_DONE;
               end else begin
                  state_in = SQ_EXT_LINK;
               end
            end else if (ptr_inc == n_ff) begin
               sts_in = STS_FULL;
               state_in = SQ_DONE;
            end else begin
               ptr_in = ptr_inc;
               state_in = SQ_SCAN_RD;
            end
         end
         SQ_EXT_LINK: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = {ENT_ALLOC, res_ff};
            est_in = ENT_ALLOC;
            enx_in = res_ff;
            state_in = SQ_DONE;
         end
         SQ_WALK_RD: begin
            state_in = SQ_WALK_CK;
         end
         SQ_WALK_CK: begin
            state_in = (cmd_ff == CMD_SHRINK) ? SQ_FIX : SQ_DONE;
            if (rd_state == ENT_FREE) begin
               sts_in = STS_BROKEN;
            end else begin
               // release this link
               mem_wr_en = 1'b1;
               if (used_ff != '0) begin
                  used_in = used_ff - 1'b1;
               end
               if (ptr_ff[IDX_W-1:0] == idx_ff) begin
                  flag_in = 1'b1;
               end
               if (rd_state != ENT_ALLOC) begin
                  sts_in = STS_OK;
               end else if ({1'b0, rd_link} >= n_ff || steps_inc >= n_ff) begin
                  sts_in = STS_BROKEN;
               end else begin
                  ptr_in = {1'b0, rd_link};
                  steps_in = steps_inc;
                  state_in = SQ_WALK_RD;
               end
            end
         end
         SQ_FIX: begin
            // a cycle in the chain freed the addressed cluster: restore it
            if (flag_ff) begin
               mem_wr_en = 1'b1;
               mem_wr_addr = idx_ff;
               mem_wr_data = {ENT_LAST, {IDX_W{1'b0}}};
               used_in = used_ff + 1'b1;
            end
            state_in = SQ_DONE;
         end
         SQ_DONE: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1;
               o_sts_in = sts_ff;
               o_res_in = res_ff;
               o_est_in = est_ff;
               o_enx_in = enx_ff;
               o_cnt_in = used_ff;
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_CLEAR;
         clr_ff <= '0;
         used_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      n_ff <= n_in;
      ptr_ff <= ptr_in;
      steps_ff <= steps_in;
      flag_ff <= flag_in;
      sts_ff <= sts_in;
      res_ff <= res_in;
      est_ff <= est_in;
      enx_ff <= enx_in;
      o_sts_ff <= o_sts_in;
      o_res_ff <= o_res_in;
      o_est_ff <= o_est_in;
      o_enx_ff <= o_enx_in;
      o_cnt_ff <= o_cnt_in;
   end

   assign req_stall = (state_ff != SQ_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_status = o_sts_ff;
   assign rsp_result_index = o_res_ff;
   assign rsp_entry_state = o_est_ff;
   assign rsp_entry_next = o_enx_ff;
   assign rsp_allocated_count = o_cnt_ff;
endmodule
`default_nettype wire

### hdl/cca_checker.sv
// Port checker of the cluster chain allocator and its bind.
`default_nettype none
`include "cluster_chain_allocator_defines.svh"
module cca_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [cca_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [cca_pkg::IDX_W-1:0]    rsp_result_index,
   input wire logic [cca_pkg::STATE_W-1:0]  rsp_entry_state,
   input wire logic [cca_pkg::IDX_W-1:0]    rsp_entry_next,
   input wire logic [cca_pkg::CNT_W-1:0]    rsp_allocated_count
);
   import cca_pkg::*;

   `CCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")
   `CCA_ASSERT_NOW(a_status_code, rsp_valid, rsp_status <= STS_BROKEN, "undefined status")
   `CCA_ASSERT_NOW(a_count_bound, rsp_valid, rsp_allocated_count <= TABLE_SIZE, "count overflow")
   `CCA_ASSERT_NOW(a_bad_index_clean, rsp_valid && rsp_status == STS_BAD_INDEX, rsp_entry_state == ENT_FREE && rsp_entry_next == '0 && rsp_result_index == '0, "bad index carries data")
   `CCA_ASSERT_NOW(a_link_only_alloc, rsp_valid && rsp_entry_state != ENT_ALLOC, rsp_entry_next == '0, "link on non-allocated entry")
endmodule

bind cluster_chain_allocator cca_checker u_cca_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_result_index    (rsp_result_index),
   .rsp_entry_state     (rsp_entry_state),
   .rsp_entry_next      (rsp_entry_next),
   .rsp_allocated_count (rsp_allocated_count)
);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the cluster chain allocator: table commands, checked per field.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import cca_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd5;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    result_index;
      logic [STATE_W-1:0]  entry_state;
      logic [IDX_W-1:0]    entry_next;
      logic [CNT_W-1:0]    allocated_count;
   } alloc_result_type;

   class alloc_scoreboard;
      logic [STATE_W-1:0] ent_state[TABLE_ENTRIES];
      logic [IDX_W-1:0]   ent_link[TABLE_ENTRIES];
      int unsigned        used;
      int unsigned        active;
      alloc_result_type   expected_q[$];
      int                 errors;
      int                 results_seen;

      function new();
         foreach (ent_state[i]) begin
            ent_state[i] = ENT_FREE;
            ent_link[i] = '0;
         end
         used = 0;
         active = TABLE_ENTRIES;
         errors = 0;
         results_seen = 0;
      endfunction

      function void set_limit(int unsigned v);
         active = (v < TABLE_ENTRIES) ? v : TABLE_ENTRIES;
      endfunction

      function int lowest_free();
         for (int i = 0; i < active; i++)
            if (ent_state[i] == ENT_FREE) return i;
         return -1;
      endfunction

      function void release_entry(int i);
         if (ent_state[i] != ENT_FREE && used > 0) used--;
         ent_state[i] = ENT_FREE;
         ent_link[i] = '0;
      endfunction

      // walk a chain and free it; bounded by the active count
      function logic [STATUS_W-1:0] free_walk(int start);
         int cur;
         logic [STATE_W-1:0] st;
         int nxt;
         cur = start;
         for (int steps = 0; steps < active; steps++) begin
            st = ent_state[cur];
            nxt = ent_link[cur];
            if (st == ENT_FREE) return STS_BROKEN;
            release_entry(cur);
            if (st != ENT_ALLOC) return STS_OK;
            if (nxt >= active) return STS_BROKEN;
            cur = nxt;
         end
         return STS_BROKEN;
      endfunction

      function void note_input(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx);
         alloc_result_type r;
         logic [STATE_W-1:0] st;
         int slot;
         int nxt;
         bit show;
         r = '{STS_OK, '0, ENT_FREE, '0, '0};
         show = 0;
         if (cmd == CMD_ALLOC) begin
            slot = lowest_free();
            if (slot < 0) r.status = STS_FULL;
            else begin
               ent_state[slot] = ENT_LAST;
               ent_link[slot] = '0;
               used++;
               r.result_index = IDX_W'(slot);
               r.entry_state = ENT_LAST;
            end
         end else if (cmd <= CMD_READ) begin
            if (idx >= active) r.status = STS_BAD_INDEX;
            else begin
               st = ent_state[idx];
               show = 1;
               case (cmd)
                  CMD_EXTEND: begin
                     if (st == ENT_FREE) r.status = STS_NOT_ALLOC;
                     else if (st != ENT_LAST) r.status = STS_NOT_LAST;
                     else begin
                        slot = lowest_free();
                        if (slot < 0) r.status = STS_FULL;
                        else begin
                           ent_state[slot] = ENT_LAST;
                           ent_link[slot] = '0;
                           used++;
                           ent_state[idx] = ENT_ALLOC;
                           ent_link[idx] = IDX_W'(slot);
                           r.result_index = IDX_W'(slot);
                        end
                     end
                  end
                  CMD_FREE: begin
                     if (st == ENT_FREE) r.status = STS_NOT_ALLOC;
                     else r.status = free_walk(idx);
                  end
                  CMD_SHRINK: begin
                     if (st == ENT_FREE) r.status = STS_NOT_ALLOC;
                     else if (st == ENT_ALLOC) begin
                        nxt = ent_link[idx];
                        ent_state[idx] = ENT_LAST;
                        ent_link[idx] = '0;
                        if (nxt >= active || ent_state[nxt] == ENT_FREE)
                           r.status = STS_BROKEN;
                        else r.status = free_walk(nxt);
                        // a cycle can free the addressed cluster; restore it as last
                        if (ent_state[idx] == ENT_FREE) begin
                           ent_state[idx] = ENT_LAST;
                           used++;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (show) begin
            r.entry_state = ent_state[idx];
            r.entry_next = (r.entry_state == ENT_ALLOC) ? ent_link[idx] : '0;
         end
         r.allocated_count = CNT_W'(used);
         expected_q.insert(expected_q.size(), r);
      endfunction

      // probe up to 12 random entries for one in the wanted state, or for any used one
      function int pick(logic [STATE_W-1:0] want, bit any_used);
         int i;
         i = $urandom_range(active - 1);
         for (int t = 0; t < 12; t++) begin
            if (any_used ? (ent_state[i] != ENT_FREE) : (ent_state[i] == want)) return i;
            i = $urandom_range(active - 1);
         end
         return i;
      endfunction

      task report(string what, int got, int want);
         $display("MISMATCH result %0d: %s got %0d want %0d", results_seen, what, got, want);
         errors++;
      endtask

      task check_result(alloc_result_type got);
         alloc_result_type w;
         results_seen++;
         if (expected_q.size() == 0) begin
            report("unexpected transfer, status", got.status, 0);
            return;
         end
         w = expected_q.pop_front();
         if (got.status !== w.status) report("status", got.status, w.status);
         if (got.result_index !== w.result_index)
            report("result_index", got.result_index, w.result_index);
         if (got.entry_state !== w.entry_state)
            report("entry_state", got.entry_state, w.entry_state);
         if (got.entry_next !== w.entry_next)
            report("entry_next", got.entry_next, w.entry_next);
         if (got.allocated_count !== w.allocated_count)
            report("allocated_count", got.allocated_count, w.allocated_count);
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CMD_W-1:0] req_cmd;
   logic [IDX_W-1:0] req_cluster_index;
   logic rsp_valid;
   logic rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0] rsp_result_index;
   logic [STATE_W-1:0] rsp_entry_state;
   logic [IDX_W-1:0] rsp_entry_next;
   logic [CNT_W-1:0] rsp_allocated_count;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   alloc_scoreboard chain_sb;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;
   int hold_left;
   int quiet_cycles;
   int items_sent;

   cluster_chain_allocator uut (.*);

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      chain_sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_cluster_index = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 10;
      recv_idle_pct = 46;
      hold_request = 0;
      hold_left = 0;
      quiet_cycles = 0;
      items_sent = 0;
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_request) begin
         hold_request = 0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) chain_sb.note_input(req_cmd, req_cluster_index);
      if (!reset && rsp_valid && !rsp_stall)
         chain_sb.check_result('{rsp_status, rsp_result_index, rsp_entry_state,
                                rsp_entry_next, rsp_allocated_count});
   end

   // watchdog over cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_cluster_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chain_sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_limit(input int unsigned v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * REG_CLUSTERS_IN_USE);
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      chain_sb.set_limit(v);
   endtask

   task run_random(input int count);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 22) send_item(CMD_ALLOC, IDX_W'($urandom_range(TABLE_ENTRIES - 1)));
         else if (r < 44) send_item(CMD_EXTEND, IDX_W'(chain_sb.pick(ENT_LAST, 0)));
         else if (r < 56) send_item(CMD_FREE, IDX_W'(chain_sb.pick(ENT_ALLOC, 1)));
         else if (r < 68) send_item(CMD_SHRINK, IDX_W'(chain_sb.pick(ENT_ALLOC, 0)));
         else if (r < 80) send_item(CMD_READ, IDX_W'(chain_sb.pick(ENT_ALLOC, 1)));
         else if (r < 93)
            send_item(CMD_W'($urandom_range(CMD_READ)),
                      IDX_W'($urandom_range(TABLE_ENTRIES - 1)));
         else send_item(CMD_W'(CMD_SPARE + $urandom_range(2)),
                        IDX_W'($urandom_range(TABLE_ENTRIES - 1)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_limit(TABLE_ENTRIES);
      @(posedge clock);

      // directed: every command, plus the not-last and not-allocated statuses
      send_item(CMD_ALLOC, 10'h3FF);
      send_item(CMD_ALLOC, 10'h000);
      send_item(CMD_EXTEND, 10'd0);
      send_item(CMD_EXTEND, 10'd0);
      send_item(CMD_EXTEND, 10'd2);
      send_item(CMD_READ, 10'd0);
      send_item(CMD_READ, 10'd1023);
      send_item(CMD_SHRINK, 10'd1);
      send_item(CMD_SHRINK, 10'd0);
      send_item(CMD_FREE, 10'd5);
      send_item(CMD_EXTEND, 10'd7);
      send_item(CMD_SHRINK, 10'd9);
      send_item(CMD_SPARE, 10'h2AA);
      send_item(CMD_SPARE + 3'd1, 10'h155);
      send_item(CMD_SPARE + 3'd2, 10'h3FF);
      send_item(CMD_EXTEND, 10'd0);
      send_item(CMD_EXTEND, 10'd2);
      send_item(CMD_EXTEND, 10'd3);
      drain();
      // shrink the range under live chains: bad index, full, broken walks
      write_limit(2);
      send_item(CMD_READ, 10'd1023);
      send_item(CMD_ALLOC, 10'd0);
      send_item(CMD_EXTEND, 10'd1);
      send_item(CMD_SHRINK, 10'd0);
      send_item(CMD_FREE, 10'd0);
      send_item(CMD_FREE, 10'd1);
      drain();

      write_limit(1);
      run_random(40);
      drain();
      write_limit(24);
      run_random(200);
      drain();
      send_idle_pct = 46;
      recv_idle_pct = 10;
      write_limit(100);
      run_random(160);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(TABLE_ENTRIES);
      hold_request = 1;
      run_random(155);
      drain();

      repeat (20) @(posedge clock);
      $display("covered %0d commands over range limits 1, 2, 24, 100 and %0d", items_sent,
               TABLE_ENTRIES);
      $display("checked %0d results, %0d field mismatches, %0d results missing",
               chain_sb.results_seen, chain_sb.errors, chain_sb.expected_q.size());
      if (chain_sb.errors == 0 && chain_sb.expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/cca_pkg.sv
hdl/cca_ram.sv
hdl/cca_csr.sv
hdl/cca_seq.sv
hdl/cluster_chain_allocator.sv
hdl/cca_checker.sv
tb/tb_top.sv
